>>> hw/rtl/dlh_pkg.sv
// Shared types and constants for the dual-lane 128-bit fingerprint unit.
// No dependencies; imported by every module of the block but dlh_checker.
`timescale 1ns / 1ps
`default_nettype none

package dlh_pkg;

    localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
    localparam logic [63:0] GOLDEN_ADD  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] LANE_B_MUL  = 64'd14029467366897019727;
    localparam logic [63:0] MIX_MUL_ONE = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_TWO = 64'h94d049bb133111eb;
    localparam logic [63:0] LANE_A_INIT = 64'd1469598103934665603;
    localparam logic [63:0] LANE_B_INIT = 64'h6a09e667f3bcc909;

    localparam int DEFAULT_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } q_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_FIN_A1,
        S_FIN_A2,
        S_FIN_B1,
        S_FIN_B2,
        S_OUT
    } core_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/dual_lane_hash128_fingerprint_unit.sv
// Top level of the dual-lane 128-bit fingerprint unit.
// Depends on dlh_pkg, dlh_front, dlh_core (and through it dlh_mul64).
//
// Bytes stream in one transaction each; the transaction with end_of_message
// set closes the message and yields one 128-bit digest (digest_high is the
// finalised FNV-1a-step lane with a non-standard offset basis, digest_low the
// finalised second lane mixed with it), after which both lanes restart from
// their initial values. An ordinary byte occupies the hashing core while each
// lane's 64-bit multiply runs on its own 32x32 multiplier as three partial
// products, between one issue and one update step. A closing byte adds four
// more dependent multiplies on one multiplier for the finaliser before the
// digest appears. A short input queue accepts bytes while the core is busy
// until it is full, and the digest sits in an output register so the next
// message can be absorbed while it waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module dual_lane_hash128_fingerprint_unit
    import dlh_pkg::*;
#(
    parameter int QueueDepth = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      digest_high,
    output logic [63:0]      digest_low
);

    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;

    dlh_front #(
        .QueueDepth (QueueDepth)
    ) u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    dlh_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .digest_high (digest_high),
        .digest_low  (digest_low),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

`default_nettype wire

>>> hw/rtl/dlh_mul64.sv
// Iterative 64x64 multiplier returning the low 64 bits of the product.
// One 32x32 partial product per cycle; depends on dlh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlh_mul64
    import dlh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mul_req_t    req,
    output logic             done,
    output logic [63:0]      product
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] pp_w;

    // low x low, high x low, low x high; only the low half of a cross term matters
    always_comb
    begin
        case (cnt_reg)
            2'd1:
            begin
                op_a = a_reg[63:32];
                op_b = b_reg[31:0];
            end
            2'd2:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[63:32];
            end
            default:
            begin
                op_a = a_reg[31:0];
                op_b = b_reg[31:0];
            end
        endcase
    end

    assign pp_w = {32'h0, op_a} * {32'h0, op_b};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            case (cnt_reg)
                2'd1:    acc_next = pp_reg;
                2'd2:    acc_next = acc_reg + {pp_reg[31:0], 32'h0};
                2'd3:
                begin
                    acc_next  = acc_reg + {pp_reg[31:0], 32'h0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: acc_next = acc_reg;
            endcase
        end
        if (req.start)
        begin
            cnt_next  = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        pp_reg  <= pp_w;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dlh_front.sv
// Input side: takes byte transactions and queues them for the hashing core.
// Small register queue; depends on dlh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dlh_front
    import dlh_pkg::*;
#(
    parameter int QueueDepth = DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_message,
    output logic            q_valid,
    output q_item_t         q_item,
    input  wire logic       q_pop
);

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] LastSlot = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] FullCnt  = CntW'(QueueDepth);

    q_item_t         slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            push;
    logic            pop;

    assign in_ready = (cnt_reg != FullCnt);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].data <= data_byte;
            slot_reg[wr_ptr_reg].last <= end_of_message;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dlh_core.sv
// Hashing core: absorbs queued bytes into both lanes, finalizes on the last
// byte and holds the digest in the output register. Depends on dlh_pkg, dlh_mul64.
`timescale 1ns / 1ps
`default_nettype none

module dlh_core
    import dlh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire q_item_t     q_item,
    output logic             q_pop,
    output logic [63:0]      digest_high,
    output logic [63:0]      digest_low,
    output logic             out_valid,
    input  wire logic        out_ready
);

    core_state_t state_reg;
    core_state_t state_next;
    logic [63:0] lane_a_reg;
    logic [63:0] lane_a_next;
    logic [63:0] lane_b_reg;
    logic [63:0] lane_b_next;
    logic        last_reg;
    logic        last_next;
    logic [63:0] hi_reg;
    logic [63:0] hi_next;
    logic [63:0] lo_reg;
    logic [63:0] lo_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] dig_hi_reg;
    logic [63:0] dig_lo_reg;
    logic        out_load;

    mul_req_t    mul_a_req;
    mul_req_t    mul_b_req;
    logic        mul_a_done;
    logic        mul_b_done;
    logic [63:0] mul_a_p;
    logic [63:0] mul_b_p;

    logic [63:0] byte_w;
    logic [63:0] mix_a_w;
    logic [63:0] mix_b_w;
    logic [63:0] out_w;
    logic [63:0] fin_b_in_w;

    dlh_mul64 u_mul_a
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_a_req),
        .done    (mul_a_done),
        .product (mul_a_p)
    );

    dlh_mul64 u_mul_b
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_b_req),
        .done    (mul_b_done),
        .product (mul_b_p)
    );

    assign byte_w     = {56'h0, q_item.data};
    assign mix_a_w    = mul_a_p ^ (mul_a_p >> 30);
    assign mix_b_w    = mul_a_p ^ (mul_a_p >> 27);
    assign out_w      = mul_a_p ^ (mul_a_p >> 31);
    assign fin_b_in_w = lane_b_reg ^ out_w;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_ABSORB;
            S_ABSORB:
            begin
                if (mul_a_done && mul_b_done)
                    state_next = last_reg ? S_FIN_A1 : S_IDLE;
            end
            S_FIN_A1: if (mul_a_done) state_next = S_FIN_A2;
            S_FIN_A2: if (mul_a_done) state_next = S_FIN_B1;
            S_FIN_B1: if (mul_a_done) state_next = S_FIN_B2;
            S_FIN_B2: if (mul_a_done) state_next = S_OUT;
            S_OUT:    if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb
    begin
        q_pop       = 1'b0;
        mul_a_req   = '0;
        mul_b_req   = '0;
        lane_a_next = lane_a_reg;
        lane_b_next = lane_b_reg;
        last_next   = last_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop           = 1'b1;
                    last_next       = q_item.last;
                    mul_a_req.start = 1'b1;
                    mul_a_req.a     = lane_a_reg ^ byte_w;
                    mul_a_req.b     = FNV_PRIME;
                    mul_b_req.start = 1'b1;
                    mul_b_req.a     = lane_b_reg ^ (byte_w + GOLDEN_ADD);
                    mul_b_req.b     = LANE_B_MUL;
                end
            end
            S_ABSORB:
            begin
                if (mul_a_done && mul_b_done)
                begin
                    lane_a_next = mul_a_p;
                    lane_b_next = mul_b_p ^ (mul_b_p >> 29);
                    if (last_reg)
                    begin
                        mul_a_req.start = 1'b1;
                        mul_a_req.a     = mix_a_w;
                        mul_a_req.b     = MIX_MUL_ONE;
                    end
                end
            end
            S_FIN_A1, S_FIN_B1:
            begin
                if (mul_a_done)
                begin
                    mul_a_req.start = 1'b1;
                    mul_a_req.a     = mix_b_w;
                    mul_a_req.b     = MIX_MUL_TWO;
                end
            end
            S_FIN_A2:
            begin
                if (mul_a_done)
                begin
                    hi_next         = out_w;
                    mul_a_req.start = 1'b1;
                    mul_a_req.a     = fin_b_in_w ^ (fin_b_in_w >> 30);
                    mul_a_req.b     = MIX_MUL_ONE;
                end
            end
            S_FIN_B2:
            begin
                if (mul_a_done)
                    lo_next = out_w;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load    = 1'b1;
                    lane_a_next = LANE_A_INIT;
                    lane_b_next = LANE_B_INIT;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_a_reg    <= LANE_A_INIT;
            lane_b_reg    <= LANE_B_INIT;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_a_reg    <= lane_a_next;
            lane_b_reg    <= lane_b_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (out_load)
        begin
            dig_hi_reg <= hi_reg;
            dig_lo_reg <= lo_reg;
        end
    end

    assign digest_high = dig_hi_reg;
    assign digest_low  = dig_lo_reg;
    assign out_valid   = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dlh_checker.sv
// Port-level checks for the fingerprint unit, bound to the top level.
// Depends on dual_lane_hash128_fingerprint_unit.
`timescale 1ns / 1ps
`default_nettype none

module dlh_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        end_of_message,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [63:0] digest_high,
    input  wire logic [63:0] digest_low
);

    // a digest transaction stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("digest dropped before transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(digest_high) && $stable(digest_low))
        else $error("digest changed while stalled");

    // finalisation runs four dependent multiplies: no digest right after a closing byte
    a_no_instant_digest: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready && end_of_message))
        else $error("digest appeared too soon after closing byte");

    // the queue only fills on an input transaction
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("in_ready dropped without an input transaction");

endmodule

bind dual_lane_hash128_fingerprint_unit dlh_checker u_dlh_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_high    (digest_high),
    .digest_low     (digest_low)
);

`default_nettype wire
